// ----- rtl/core/cfir_pkg.sv -----
// Shared types and constants for the complex FIR filter core.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
package cfir_pkg;

	// Command codes carried by an input beat.
	typedef enum logic [1:0] {
		CMD_FILTER = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// One complex 16-bit value.
	typedef struct packed {
		logic signed [15:0] re;
		logic signed [15:0] im;
	} cplx_t;

	// A beat as it travels down the cell chain.
	typedef struct packed {
		logic       valid;
		cmd_t       cmd;
		logic [4:0] tap_index;
		cplx_t      value;
	} beat_t;

	// Width of one complex product part: a*c - b*d needs one bit over 32.
	localparam int PROD_W = 33;
	typedef logic signed [PROD_W-1:0] prod_t;

	// Output saturation limits.
	localparam logic signed [15:0] OUT_MAX = 16'sh7fff;
	localparam logic signed [15:0] OUT_MIN = -16'sh8000;

	// Configuration register map.
	localparam int APB_ADDR_W = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_SHIFT_AMOUNT = 2'd0;
	localparam logic [5:0] SHIFT_RESET = 6'd15;

endpackage

// ----- rtl/core/complex_fir_32tap_unit.sv -----
// Top level of the complex FIR filter: APB register, cell chain and tail.
// Depends on cfir_pkg, cfir_cell and cfir_tail.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  cmd      | cmd_valid / cmd_stall  | command, tap_index, value_re, value_im
//  res      | res_valid / res_stall  | out_re, out_im
//  apb      | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// One beat is accepted every cycle unless cmd_stall holds it off. A filter
// result is presented after its beat has walked the chain: the first cell
// captures the beat at the edge that accepts it, the beat walks the remaining
// cells one per cycle while the chain advances, then passes the final add and
// the result register. The whole chain freezes only while a finished result
// waits in the tail behind a stalled result register. Reset clears all taps,
// all history and the shift register to 15; no clearing pass is needed.
module complex_fir_32tap_unit #(
	parameter int TAP_COUNT = 32,
	parameter int ACC_WIDTH = 48
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [1:0]                        command,
	input  logic [4:0]                        tap_index,
	input  logic signed [15:0]                value_re,
	input  logic signed [15:0]                value_im,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic signed [15:0]                out_re,
	output logic signed [15:0]                out_im,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cfir_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	logic            advance;
	logic [5:0]      shift_amount_q;
	cfir_pkg::beat_t chain_beat [TAP_COUNT+1];
	acc_t            chain_sum_re [TAP_COUNT+1];
	acc_t            chain_sum_im [TAP_COUNT+1];
	cfir_pkg::prod_t chain_prod_re [TAP_COUNT+1];
	cfir_pkg::prod_t chain_prod_im [TAP_COUNT+1];

	// Shift register, written on the APB access cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_amount_q <= cfir_pkg::SHIFT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr == cfir_pkg::ADDR_SHIFT_AMOUNT) begin
			shift_amount_q <= pwdata[5:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == cfir_pkg::ADDR_SHIFT_AMOUNT) ? {26'd0, shift_amount_q} : 32'd0;

	// Input beat enters the head of the chain.
	assign cmd_stall = !advance;

	assign chain_beat[0].valid     = cmd_valid && !cmd_stall;
	assign chain_beat[0].cmd       = cfir_pkg::cmd_t'(command);
	assign chain_beat[0].tap_index = tap_index;
	assign chain_beat[0].value.re  = value_re;
	assign chain_beat[0].value.im  = value_im;

	assign chain_sum_re[0]  = '0;
	assign chain_sum_im[0]  = '0;
	assign chain_prod_re[0] = '0;
	assign chain_prod_im[0] = '0;

	// Chain position c holds the tap and history entry TAP_COUNT-1-c.
	for (genvar c = 0; c < TAP_COUNT; c++) begin : g_cell
		cfir_cell #(
			.ACC_WIDTH (ACC_WIDTH),
			.TAP_IDX   (TAP_COUNT - 1 - c)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.beat_i    (chain_beat[c]),
			.sum_re_i  (chain_sum_re[c]),
			.sum_im_i  (chain_sum_im[c]),
			.prod_re_i (chain_prod_re[c]),
			.prod_im_i (chain_prod_im[c]),
			.beat_o    (chain_beat[c+1]),
			.sum_re_o  (chain_sum_re[c+1]),
			.sum_im_o  (chain_sum_im[c+1]),
			.prod_re_o (chain_prod_re[c+1]),
			.prod_im_o (chain_prod_im[c+1])
		);
	end

	// Final add, narrowing and result register.
	cfir_tail #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat_i       (chain_beat[TAP_COUNT]),
		.sum_re_i     (chain_sum_re[TAP_COUNT]),
		.sum_im_i     (chain_sum_im[TAP_COUNT]),
		.prod_re_i    (chain_prod_re[TAP_COUNT]),
		.prod_im_i    (chain_prod_im[TAP_COUNT]),
		.shift_amount (shift_amount_q),
		.res_stall    (res_stall),
		.advance      (advance),
		.res_valid    (res_valid),
		.out_re       (out_re),
		.out_im       (out_im)
	);

	// Input is held off only behind a waiting, stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled without a blocked result");

endmodule

// ----- rtl/core/cfir_cell.sv -----
// One cell of the complex FIR chain: holds one tap and one history sample.
// Depends on cfir_pkg for the beat, complex and product types.
module cfir_cell #(
	parameter int ACC_WIDTH = 48,
	parameter int TAP_IDX   = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  cfir_pkg::beat_t            beat_i,
	input  logic signed [ACC_WIDTH-1:0] sum_re_i,
	input  logic signed [ACC_WIDTH-1:0] sum_im_i,
	input  cfir_pkg::prod_t            prod_re_i,
	input  cfir_pkg::prod_t            prod_im_i,
	output cfir_pkg::beat_t            beat_o,
	output logic signed [ACC_WIDTH-1:0] sum_re_o,
	output logic signed [ACC_WIDTH-1:0] sum_im_o,
	output cfir_pkg::prod_t            prod_re_o,
	output cfir_pkg::prod_t            prod_im_o
);

	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	cfir_pkg::cplx_t tap_q;
	cfir_pkg::cplx_t hist_q;
	cfir_pkg::beat_t beat_q;
	acc_t            sum_re_q;
	acc_t            sum_im_q;
	cfir_pkg::prod_t prod_re_q;
	cfir_pkg::prod_t prod_im_q;

	logic signed [31:0] ac, bd, ad, bc;
	cfir_pkg::beat_t    beat_d;
	logic               tap_hit;

	// Complex product of this cell's tap and history sample.
	always_comb begin
		ac = tap_q.re * hist_q.re;
		bd = tap_q.im * hist_q.im;
		ad = tap_q.re * hist_q.im;
		bc = tap_q.im * hist_q.re;
	end

	// A passing filter beat carries the displaced history sample onward.
	always_comb begin
		beat_d = beat_i;
		if (beat_i.cmd == cfir_pkg::CMD_FILTER) begin
			beat_d.value = hist_q;
		end
		tap_hit = (int'(beat_i.tap_index) == TAP_IDX);
	end

	// Per-cell state update as a beat passes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= '0;
			hist_q <= '0;
			beat_q <= '0;
		end else if (advance) begin
			beat_q <= beat_d;
			if (beat_i.valid) begin
				case (beat_i.cmd)
					cfir_pkg::CMD_FILTER: hist_q <= beat_i.value;
					cfir_pkg::CMD_LOAD: begin
						if (tap_hit) begin
							tap_q <= beat_i.value;
						end
					end
					cfir_pkg::CMD_CLEAR: hist_q <= '0;
					default: ;
				endcase
			end
		end
	end

	// Product register and running sum; the previous cell's product joins here.
	always_ff @(posedge clk) begin
		if (advance) begin
			prod_re_q <= cfir_pkg::prod_t'(ac) - cfir_pkg::prod_t'(bd);
			prod_im_q <= cfir_pkg::prod_t'(ad) + cfir_pkg::prod_t'(bc);
			sum_re_q  <= sum_re_i + acc_t'(prod_re_i);
			sum_im_q  <= sum_im_i + acc_t'(prod_im_i);
		end
	end

	assign beat_o    = beat_q;
	assign sum_re_o  = sum_re_q;
	assign sum_im_o  = sum_im_q;
	assign prod_re_o = prod_re_q;
	assign prod_im_o = prod_im_q;

	// The cell state must hold while the chain is frozen.
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(tap_q) && $stable(hist_q) && $stable(beat_q))
		else $error("cell state changed while the chain was frozen");

endmodule

// ----- rtl/core/cfir_tail.sv -----
// Tail of the complex FIR chain: final add, shift and saturate, result register.
// Depends on cfir_pkg for the beat type and saturation limits.
module cfir_tail #(
	parameter int ACC_WIDTH = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cfir_pkg::beat_t             beat_i,
	input  logic signed [ACC_WIDTH-1:0] sum_re_i,
	input  logic signed [ACC_WIDTH-1:0] sum_im_i,
	input  cfir_pkg::prod_t             prod_re_i,
	input  cfir_pkg::prod_t             prod_im_i,
	input  logic [5:0]                  shift_amount,
	input  logic                        res_stall,
	output logic                        advance,
	output logic                        res_valid,
	output logic signed [15:0]          out_re,
	output logic signed [15:0]          out_im
);

	typedef logic signed [ACC_WIDTH-1:0] acc_t;

	logic               v_s1;
	acc_t               acc_re_s1;
	acc_t               acc_im_s1;
	logic               res_valid_q;
	logic signed [15:0] out_re_q;
	logic signed [15:0] out_im_q;

	// Arithmetic shift right, then clamp to the 16-bit range.
	function automatic logic signed [15:0] narrow(acc_t acc, logic [5:0] sh);
		acc_t v;
		v = acc >>> sh;
		if (v > acc_t'(cfir_pkg::OUT_MAX)) begin
			return cfir_pkg::OUT_MAX;
		end else if (v < acc_t'(cfir_pkg::OUT_MIN)) begin
			return cfir_pkg::OUT_MIN;
		end
		return v[15:0];
	endfunction

	// The chain freezes only when a finished sum has nowhere to go.
	assign advance = !(v_s1 && res_valid_q && res_stall);

	// Final accumulation stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= beat_i.valid && (beat_i.cmd == cfir_pkg::CMD_FILTER);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_re_s1 <= sum_re_i + acc_t'(prod_re_i);
			acc_im_s1 <= sum_im_i + acc_t'(prod_im_i);
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && v_s1) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			out_re_q <= narrow(acc_re_s1, shift_amount);
			out_im_q <= narrow(acc_im_s1, shift_amount);
		end
	end

	assign res_valid = res_valid_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;

	// A new result appears only from a finished filter sum.
	a_rise_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(v_s1))
		else $error("result beat appeared without a finished sum");

	// A taken result with nothing behind it empties the register.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_stall && !v_s1 |=> !res_valid_q)
		else $error("result register did not drain");

endmodule

// ----- dv/cfir_checker.sv -----
// Checker for the complex FIR filter: it follows the command, result and APB channels,
// keeps its own copy of taps, sample history and shift, and compares every result beat.
// Depends on cfir_pkg for the command codes and the complex value type.
module cfir_checker #(
	parameter int TAP_COUNT = 32,
	parameter int ACC_WIDTH = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cmd_valid,
	input  logic                            cmd_stall,
	input  logic [1:0]                      command,
	input  logic [4:0]                      tap_index,
	input  logic signed [15:0]              value_re,
	input  logic signed [15:0]              value_im,
	input  logic                            res_valid,
	input  logic                            res_stall,
	input  logic signed [15:0]              out_re,
	input  logic signed [15:0]              out_im,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [cfir_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output int                              mismatches,
	output int                              outputs_waiting,
	output int                              outputs_checked
);

	// Mirror of the filter state.
	logic signed [15:0] tap_re [TAP_COUNT];
	logic signed [15:0] tap_im [TAP_COUNT];
	logic signed [15:0] hist_re [TAP_COUNT];
	logic signed [15:0] hist_im [TAP_COUNT];
	logic [5:0]         shift_amount;

	// Filtered samples still owed by the block, oldest first.
	cfir_pkg::cplx_t pending_outputs [$];

	// Wraps a sum to the accumulator width, shifts it right arithmetically and saturates it.
	function automatic logic signed [15:0] narrow_sum(input longint sum);
		logic signed [ACC_WIDTH-1:0] wrapped;
		longint scaled;
		wrapped = sum[ACC_WIDTH-1:0];
		scaled = longint'(wrapped) >>> shift_amount;
		if (scaled > longint'(cfir_pkg::OUT_MAX))
			return cfir_pkg::OUT_MAX;
		if (scaled < longint'(cfir_pkg::OUT_MIN))
			return cfir_pkg::OUT_MIN;
		return scaled[15:0];
	endfunction

	// Complex dot product of the taps with the prior samples, oldest sample on tap 0.
	function automatic cfir_pkg::cplx_t fir_output();
		longint sum_re;
		longint sum_im;
		cfir_pkg::cplx_t result;
		sum_re = 0;
		sum_im = 0;
		for (int k = 0; k < TAP_COUNT; k++) begin
			sum_re += longint'(tap_re[k]) * longint'(hist_re[k])
				- longint'(tap_im[k]) * longint'(hist_im[k]);
			sum_im += longint'(tap_re[k]) * longint'(hist_im[k])
				+ longint'(tap_im[k]) * longint'(hist_re[k]);
		end
		result.re = narrow_sum(sum_re);
		result.im = narrow_sum(sum_im);
		return result;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cfir_pkg::cplx_t expected;
		int errs;
		errs = 0;
		if (!arst_n) begin
			for (int k = 0; k < TAP_COUNT; k++) begin
				tap_re[k] = '0;
				tap_im[k] = '0;
				hist_re[k] = '0;
				hist_im[k] = '0;
			end
			shift_amount = cfir_pkg::SHIFT_RESET;
			pending_outputs.delete();
			mismatches <= 0;
			outputs_waiting <= 0;
			outputs_checked <= 0;
		end else begin
			// Result beat: compare with the oldest owed sample.
			if (res_valid && !res_stall) begin
				if (pending_outputs.size() == 0) begin
					$error("result beat with nothing expected: out_re %0d, out_im %0d",
						out_re, out_im);
					errs++;
				end else begin
					expected = pending_outputs.pop_front();
					if (out_re !== expected.re) begin
						$error("out_re: expected %0d, actual %0d", expected.re, out_re);
						errs++;
					end
					if (out_im !== expected.im) begin
						$error("out_im: expected %0d, actual %0d", expected.im, out_im);
						errs++;
					end
					outputs_checked <= outputs_checked + 1;
				end
			end
			mismatches <= mismatches + errs;

			// Command beat: update the mirror and predict a result for a filter beat.
			if (cmd_valid && !cmd_stall) begin
				case (cfir_pkg::cmd_t'(command))
					cfir_pkg::CMD_FILTER: begin
						pending_outputs.push_back(fir_output());
						for (int k = 0; k < TAP_COUNT - 1; k++) begin
							hist_re[k] = hist_re[k+1];
							hist_im[k] = hist_im[k+1];
						end
						hist_re[TAP_COUNT-1] = value_re;
						hist_im[TAP_COUNT-1] = value_im;
					end
					cfir_pkg::CMD_LOAD: begin
						if (tap_index < TAP_COUNT) begin
							tap_re[tap_index] = value_re;
							tap_im[tap_index] = value_im;
						end
					end
					cfir_pkg::CMD_CLEAR: begin
						for (int k = 0; k < TAP_COUNT; k++) begin
							hist_re[k] = '0;
							hist_im[k] = '0;
						end
					end
					default: begin
					end
				endcase
			end

			// Register write.
			if (psel && penable && pwrite && pready
					&& paddr == cfir_pkg::ADDR_SHIFT_AMOUNT)
				shift_amount = pwdata[5:0];

			outputs_waiting <= pending_outputs.size();
		end
	end

endmodule

// ----- dv/complex_fir_32tap_unit_tb.sv -----
// Top of the complex FIR filter testbench: clock, reset, stimulus, idling and verdict.
// Depends on cfir_pkg, complex_fir_32tap_unit and cfir_checker.
module complex_fir_32tap_unit_tb;

	localparam int TAP_COUNT      = 32;
	localparam int DRAIN_CYCLES   = TAP_COUNT + 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASES         = 8;
	localparam int RANDOM_BEATS   = 190;
	localparam int HOLD_CYCLES    = 300;

	logic                            clk;
	logic                            arst_n;
	logic                            cmd_valid;
	logic                            cmd_stall;
	logic [1:0]                      command;
	logic [4:0]                      tap_index;
	logic signed [15:0]              value_re;
	logic signed [15:0]              value_im;
	logic                            res_valid;
	logic                            res_stall;
	logic signed [15:0]              out_re;
	logic signed [15:0]              out_im;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [cfir_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;

	int mismatches;
	int outputs_waiting;
	int outputs_checked;

	// Idling controls for the sender and the receiver.
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_cycles;

	int filter_beats;
	int load_beats;
	int clear_beats;
	int unused_beats;
	int stalled_cycles;

	complex_fir_32tap_unit #(
		.TAP_COUNT(TAP_COUNT),
		.ACC_WIDTH(48)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.tap_index(tap_index),
		.value_re(value_re),
		.value_im(value_im),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_re(out_re),
		.out_im(out_im),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cfir_checker #(
		.TAP_COUNT(TAP_COUNT),
		.ACC_WIDTH(48)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.tap_index(tap_index),
		.value_re(value_re),
		.value_im(value_im),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_re(out_re),
		.out_im(out_im),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.outputs_waiting(outputs_waiting),
		.outputs_checked(outputs_checked)
	);

	// Clock with a period of 10.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: ends the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n) begin
			stalled_cycles <= 0;
		end else if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)
				|| (psel && penable && pready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stalls, or one long hold-off when asked for.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else begin
				res_stall <= ($urandom_range(99) < receiver_stall_pct);
			end
		end
	end

	// Sends one command beat; entered and left at a falling edge.
	task automatic send_beat(input cfir_pkg::cmd_t cmd, input logic [4:0] idx,
			input logic signed [15:0] re, input logic signed [15:0] im);
		if ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < sender_idle_pct)
				@(negedge clk);
		end
		cmd_valid <= 1'b1;
		command <= cmd;
		tap_index <= idx;
		value_re <= re;
		value_im <= im;
		do
			@(posedge clk);
		while (cmd_stall);
		@(negedge clk);
		case (cmd)
			cfir_pkg::CMD_FILTER: filter_beats++;
			cfir_pkg::CMD_LOAD:   load_beats++;
			cfir_pkg::CMD_CLEAR:  clear_beats++;
			default:              unused_beats++;
		endcase
	endtask

	// Waits until the block is idle, then writes the shift register over APB.
	task automatic write_shift(input logic [5:0] shift);
		logic [31:0] word;
		word = $urandom;
		word[5:0] = shift;
		cmd_valid <= 1'b0;
		wait (outputs_waiting == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= cfir_pkg::ADDR_SHIFT_AMOUNT;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Sample or tap value: extremes, small values near zero, or anything.
	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(9))
			0: return cfir_pkg::OUT_MAX;
			1: return cfir_pkg::OUT_MIN;
			2, 3: return 16'($urandom_range(511) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// Stimulus.
	initial begin
		logic [5:0] phase_shift [PHASES];
		int choice;

		phase_shift = '{6'd0, 6'd47, 6'd63, 6'd18, 6'd20, 6'd48, 6'd15, 6'd0};
		phase_shift[PHASES-1] = 6'($urandom_range(46, 1));

		arst_n = 1'b0;
		cmd_valid = 1'b0;
		command = cfir_pkg::CMD_NONE;
		tap_index = '0;
		value_re = '0;
		value_im = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_cycles = 0;
		filter_beats = 0;
		load_beats = 0;
		clear_beats = 0;
		unused_beats = 0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed beats at the reset shift: zero taps, extreme taps and samples,
		// the unused command, and a cleared history.
		send_beat(cfir_pkg::CMD_FILTER, 5'd31, 16'sd0, 16'sd0);
		send_beat(cfir_pkg::CMD_LOAD, 5'd0, cfir_pkg::OUT_MAX, cfir_pkg::OUT_MAX);
		send_beat(cfir_pkg::CMD_LOAD, 5'd31, cfir_pkg::OUT_MIN, cfir_pkg::OUT_MIN);
		send_beat(cfir_pkg::CMD_LOAD, 5'd16, 16'sd1, -16'sd1);
		send_beat(cfir_pkg::CMD_NONE, 5'd5, cfir_pkg::OUT_MAX, cfir_pkg::OUT_MIN);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MAX, cfir_pkg::OUT_MIN);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MIN, cfir_pkg::OUT_MAX);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MIN, cfir_pkg::OUT_MIN);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MAX, cfir_pkg::OUT_MAX);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, 16'sd1, -16'sd1);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, -16'sd1, 16'sd0);
		send_beat(cfir_pkg::CMD_CLEAR, 5'd31, cfir_pkg::OUT_MAX, cfir_pkg::OUT_MAX);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, 16'sd0, 16'sd0);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MIN, cfir_pkg::OUT_MIN);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, 16'sd1, 16'sd1);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MAX, 16'sd0);
		send_beat(cfir_pkg::CMD_LOAD, 5'd31, cfir_pkg::OUT_MAX, 16'sd0);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, cfir_pkg::OUT_MIN, 16'sd0);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, 16'sd0, 16'sd0);
		send_beat(cfir_pkg::CMD_FILTER, 5'd0, 16'sd0, 16'sd0);

		// Random phases, each with its own shift and idling mode.
		for (int phase = 0; phase < PHASES; phase++) begin
			write_shift(phase_shift[phase]);
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 50;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 50;
				end
				default: begin
					sender_idle_pct = 26;
					receiver_stall_pct = 26;
				end
			endcase
			// The receiver holds off while filter beats keep coming, so the chain fills.
			if (phase == 4)
				hold_cycles = HOLD_CYCLES;

			// Load a full set of taps, then a random command stream.
			for (int k = 0; k < TAP_COUNT; k++)
				send_beat(cfir_pkg::CMD_LOAD, 5'(k), pick_value(), pick_value());
			for (int n = 0; n < RANDOM_BEATS; n++) begin
				choice = $urandom_range(99);
				if (choice < 75)
					send_beat(cfir_pkg::CMD_FILTER, 5'($urandom), pick_value(),
						pick_value());
				else if (choice < 95)
					send_beat(cfir_pkg::CMD_LOAD, 5'($urandom), pick_value(),
						pick_value());
				else if (choice < 97)
					send_beat(cfir_pkg::CMD_CLEAR, 5'($urandom), pick_value(),
						pick_value());
				else
					send_beat(cfir_pkg::CMD_NONE, 5'($urandom), pick_value(),
						pick_value());
			end
		end

		// Drain.
		cmd_valid <= 1'b0;
		receiver_stall_pct = 0;
		wait (outputs_waiting == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d filter, %0d load, %0d clear and %0d unused beats;",
			filter_beats, load_beats, clear_beats, unused_beats);
		$display("%0d results checked with shifts from 0 to 63 under every idling mode.",
			outputs_checked);
		if (mismatches == 0 && outputs_waiting == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
